@@ src/pac_pkg.sv @@
// shared types and constants for the packet anomaly counter
package pac_pkg;

	localparam int TableEntriesDef = 64;
	localparam int CountBitsDef = 32;
	localparam int PosBits = 14;
	localparam logic [PosBits-1:0] PosMax = '1;
	localparam logic [31:0] ThresholdReset = 32'd1000;
	localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
	localparam logic [PosBits-1:0] MinSynLength = 14'd34;
	localparam logic [7:0] FlagSyn = 8'h02;
	localparam logic [7:0] FlagAck = 8'h10;
	localparam logic [1:0] ProtoTcp = 2'd1;
	localparam logic [1:0] ProtoUdp = 2'd2;
	localparam logic OpFrame = 1'b0;
	localparam logic OpClear = 1'b1;
	localparam int InBits = 80;
	localparam int OutBits = 104;

	// classified word handed from the front end to the back end
	typedef struct packed {
		logic        clear;
		logic        susp;
		logic        syn;
		logic [31:0] src;
	} pac_cmd_t;

	function automatic logic watched_port(input logic [15:0] p);
		return p == 16'd21 || p == 16'd23 || p == 16'd445 || p == 16'd3389;
	endfunction

endpackage

@@ src/pac_front.sv @@
// front end: frame byte parser and packet classifier
module pac_front import pac_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         operation,
	input  logic [7:0]   frame_byte,
	input  logic         is_last_byte,
	input  logic [1:0]   protocol_code,
	input  logic [15:0]  source_port,
	input  logic [15:0]  dest_port,
	input  logic [31:0]  source_address,
	output logic         cmd_valid,
	input  logic         cmd_ready,
	output pac_cmd_t     cmd
);

	logic [PosBits-1:0] pos_q;
	logic [15:0] etype_q;
	logic [3:0] ihl_q;
	logic [7:0] flags_q;
	logic fcap_q;
	logic accept;
	logic cap_now;
	logic [7:0] flags_n;
	logic fcap_n;
	logic [15:0] etype_n;
	logic [PosBits-1:0] flag_pos;

	assign in_ready = !cmd_valid || cmd_ready;
	assign accept = in_valid && in_ready;
	assign flag_pos = PosBits'(27) + {8'd0, ihl_q, 2'b00};
	assign cap_now = pos_q >= PosBits'(27) && pos_q == flag_pos;
	assign flags_n = cap_now ? frame_byte : flags_q;
	assign fcap_n = cap_now || fcap_q;
	assign etype_n = (pos_q == 14'd13) ? {etype_q[15:8], frame_byte} : etype_q;

	// frame parsing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			etype_q <= '0;
			ihl_q <= '0;
			flags_q <= '0;
			fcap_q <= 1'b0;
		end else if (accept && operation == OpFrame) begin
			if (is_last_byte) begin
				pos_q <= '0;
				etype_q <= '0;
				ihl_q <= '0;
				flags_q <= '0;
				fcap_q <= 1'b0;
			end else begin
				pos_q <= (pos_q == PosMax) ? PosMax : pos_q + 1'b1;
				if (pos_q == 14'd12) etype_q <= {frame_byte, 8'h00};
				else etype_q <= etype_n;
				if (pos_q == 14'd14) ihl_q <= frame_byte[3:0];
				flags_q <= flags_n;
				fcap_q <= fcap_n;
			end
		end
	end

	// output register toward the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (in_ready) begin
			cmd_valid <= accept && (operation == OpClear || is_last_byte);
		end
	end

	// frame length one bit wider so a saturated position still counts as long
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd.clear <= operation == OpClear;
			cmd.susp <= (protocol_code == ProtoTcp || protocol_code == ProtoUdp) &&
				(watched_port(source_port) || watched_port(dest_port));
			cmd.syn <= protocol_code == ProtoTcp &&
				({1'b0, pos_q} + 1'b1) >= {1'b0, MinSynLength} &&
				etype_n == EtherTypeIpv4 && fcap_n &&
				(flags_n & FlagSyn) != 8'd0 && (flags_n & FlagAck) == 8'd0;
			cmd.src <= source_address;
		end
	end

endmodule

@@ src/pac_fifo.sv @@
// short queue between front and back end
module pac_fifo import pac_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_valid,
	output logic     wr_ready,
	input  pac_cmd_t wr_data,
	output logic     rd_valid,
	input  logic     rd_ready,
	output pac_cmd_t rd_data
);

	pac_cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

endmodule

@@ src/pac_back.sv @@
// back end: totals, per-source table and result register
module pac_back import pac_pkg::*; #(
	parameter int TABLE_ENTRIES = TableEntriesDef,
	parameter int COUNT_BITS = CountBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  pac_cmd_t    cmd,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [OutBits-1:0] out_data
);

	localparam int IdxBits = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [COUNT_BITS-1:0] CntMax = '1;

	logic [31:0] thr_q;
	logic [COUNT_BITS-1:0] syn_q, port_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [31:0] key_q [TABLE_ENTRIES];
	logic [COUNT_BITS-1:0] count_q [TABLE_ENTRIES];
	logic go;
	logic s1_go;
	logic hit;
	logic free;
	logic [IdxBits-1:0] hit_idx, free_idx, lookup_idx;
	logic v_s1, clear_s1, susp_s1, syn_s1, hit_s1, untr_s1, fwd_s1;
	logic [IdxBits-1:0] idx_s1;
	logic [COUNT_BITS-1:0] rd_cnt_s1, fwd_cnt_s1;
	logic [COUNT_BITS-1:0] old_cnt, new_cnt, syn_n, port_n;
	logic heavy;
	logic [31:0] src_pk;

	assign s1_go = v_s1 && (!out_valid || out_ready);
	assign cmd_ready = !v_s1 || s1_go;
	assign go = cmd_valid && cmd_ready;
	assign lookup_idx = hit ? hit_idx : free_idx;

	// parallel key compare and lowest free entry
	always_comb begin
		hit = 1'b0;
		free = 1'b0;
		hit_idx = '0;
		free_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (valid_q[i] && key_q[i] == cmd.src) begin
				hit = 1'b1;
				hit_idx = IdxBits'(i);
			end
			if (!valid_q[i]) begin
				free = 1'b1;
				free_idx = IdxBits'(i);
			end
		end
	end

	function automatic logic [31:0] clamp(input logic [COUNT_BITS-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
	endfunction

	// count update and heavy check; a new entry starts from zero
	always_comb begin
		old_cnt = !hit_s1 ? '0 : (fwd_s1 ? fwd_cnt_s1 : rd_cnt_s1);
		new_cnt = (old_cnt == CntMax) ? CntMax : old_cnt + 1'b1;
		syn_n = (syn_s1 && syn_q != CntMax) ? syn_q + 1'b1 : syn_q;
		port_n = (susp_s1 && port_q != CntMax) ? port_q + 1'b1 : port_q;
		heavy = !untr_s1 && 64'(old_cnt) <= 64'(thr_q) && 64'(new_cnt) > 64'(thr_q);
		src_pk = untr_s1 ? 32'd0 : clamp(new_cnt);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ThresholdReset;
			syn_q <= '0;
			port_q <= '0;
			valid_q <= '0;
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) thr_q <= cfg_data;
			if (cmd_ready) v_s1 <= go;
			if (go) begin
				if (cmd.clear) valid_q <= '0;
				else if (!hit && free) valid_q[free_idx] <= 1'b1;
			end
			if (!out_valid || out_ready) out_valid <= s1_go && !clear_s1;
			if (s1_go) begin
				if (clear_s1) begin
					syn_q <= '0;
					port_q <= '0;
				end else begin
					syn_q <= syn_n;
					port_q <= port_n;
				end
			end
		end
	end

	// lookup stage: claim a new entry, bypass a count still being written
	always_ff @(posedge clk) begin
		if (go) begin
			clear_s1 <= cmd.clear;
			susp_s1 <= cmd.susp;
			syn_s1 <= cmd.syn;
			hit_s1 <= hit;
			untr_s1 <= !hit && !free;
			idx_s1 <= lookup_idx;
			fwd_s1 <= s1_go && !clear_s1 && !untr_s1 && idx_s1 == lookup_idx;
			fwd_cnt_s1 <= new_cnt;
			if (!cmd.clear && !hit && free) key_q[free_idx] <= cmd.src;
		end
	end

	// count table, one registered read and one write per cycle
	always_ff @(posedge clk) begin
		if (s1_go && !clear_s1 && !untr_s1) count_q[idx_s1] <= new_cnt;
		if (go) rd_cnt_s1 <= count_q[lookup_idx];
	end

	// result word
	always_ff @(posedge clk) begin
		if (s1_go && !clear_s1) begin
			out_data <= OutBits'({clamp(port_n), clamp(syn_n), untr_s1, heavy, src_pk,
				syn_s1, susp_s1});
		end
	end

endmodule

@@ src/packet_anomaly_counter.sv @@
// top level of the packet anomaly counter
// Frame bytes enter on the s_axis channel, one word per byte, starting at the
// Ethernet destination address. Packet metadata (protocol, ports, IPv4 source)
// is sampled with the byte that has s_axis_tlast set; tuser set means a clear
// word that zeroes both totals and empties the source table, with no result.
// For each last byte one result word leaves on m_axis: port and SYN flags, the
// per-source count, heavy and untracked flags and the two saturating totals.
// m_axis_tvalid follows the edge that takes the last byte through the front
// register, two-entry queue, table lookup stage and result register. One word
// is taken every cycle unless stalled; keys are compared in parallel and the
// count is read one stage ahead of its update, with a bypass for back-to-back
// hits. A stalled receiver holds the result register, then the lookup stage,
// the queue and the front register fill and s_axis_tready falls; the sides
// stall independently.
// Reset clears the parser, totals, table valid bits and sets heavy_threshold
// to 1000; cfg_we writes the threshold and must only be used while idle.
module packet_anomaly_counter import pac_pkg::*; #(
	parameter int TABLE_ENTRIES = TableEntriesDef,
	parameter int COUNT_BITS = CountBitsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [31:0]         cfg_data,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// frame_byte, protocol_code, source_port, dest_port, source_address, pad
	input  logic [InBits-1:0]   s_axis_tdata,
	input  logic                s_axis_tlast,
	// operation
	input  logic                s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// suspicious_port, syn_without_ack, source_packets, became_heavy,
	// source_untracked, syn_total, suspicious_total
	output logic [OutBits-1:0]  m_axis_tdata
);

	pac_cmd_t f_cmd, q_cmd;
	logic f_valid, f_ready, q_valid, q_ready;

	pac_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.operation(s_axis_tuser), .frame_byte(s_axis_tdata[7:0]),
		.is_last_byte(s_axis_tlast), .protocol_code(s_axis_tdata[9:8]),
		.source_port(s_axis_tdata[25:10]), .dest_port(s_axis_tdata[41:26]),
		.source_address(s_axis_tdata[73:42]),
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	pac_fifo u_fifo (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
	);

	pac_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk, .arst_n, .cfg_we, .cfg_data,
		.cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
	);

endmodule

@@ verif/packet_anomaly_counter_tb.sv @@
// self-checking testbench for the packet anomaly counter
module packet_anomaly_counter_tb;
	import pac_pkg::*;

	localparam int NumSources = 80;
	localparam int FillSources = 66;
	localparam int PhaseWords = 80;
	localparam int IdleLimit = 4000;
	localparam int HoldCycles = 400;
	localparam int SettleCycles = 10;

	// result word as it leaves the block
	typedef struct {
		logic        susp;
		logic        syn;
		logic [31:0] pkts;
		logic        heavy;
		logic        untracked;
		logic [31:0] syn_tot;
		logic [31:0] susp_tot;
	} verdict_t;

	// one directed frame, or a clear word when clr is set
	typedef struct {
		logic        clr;
		int          len;
		logic [15:0] etype;
		logic [3:0]  ihl;
		logic [7:0]  flags;
		logic [1:0]  proto;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [31:0] src;
		logic        e_susp;
		logic        e_syn;
		logic [31:0] e_pkts;
	} frame_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [31:0]        cfg_data = '0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [InBits-1:0]  s_axis_tdata = '0;
	logic               s_axis_tlast = 1'b0;
	logic               s_axis_tuser = 1'b0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [OutBits-1:0] m_axis_tdata;

	// predictor state
	logic [31:0]        thr_q;
	logic [PosBits-1:0] pos_q;
	logic [15:0]        etype_q;
	logic [3:0]         hw_q;
	logic [7:0]         flags_q;
	logic               captured_q;
	logic [31:0]        key_q [TableEntriesDef];
	logic [31:0]        cnt_q [TableEntriesDef];
	logic               valid_q [TableEntriesDef];
	logic [31:0]        syn_cnt_q;
	logic [31:0]        port_cnt_q;

	verdict_t           pending_verdicts[$];
	verdict_t           last_verdict;
	logic [31:0]        src_pool [NumSources];
	frame_row_t         rows[$];

	int  errors = 0;
	int  verdicts_seen = 0;
	int  bytes_sent = 0;
	int  frames_sent = 0;
	int  clears_sent = 0;
	int  untracked_seen = 0;
	int  heavy_seen = 0;
	int  idle_cycles = 0;
	bit  no_idle = 0;
	bit  hold_req = 0;
	bit  sent_all = 0;

	packet_anomaly_counter i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] act_v);
		errors++;
		if (errors <= 10)
			$display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, act_v, $realtime);
	endtask

	function automatic logic port_watched(input logic [15:0] p);
		return p == 16'd21 || p == 16'd23 || p == 16'd445 || p == 16'd3389;
	endfunction

	function automatic logic [31:0] sat_add(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	// reset state of the predictor
	task automatic model_clear_table();
		syn_cnt_q = '0;
		port_cnt_q = '0;
		foreach (valid_q[i]) begin
			valid_q[i] = 1'b0;
			key_q[i] = '0;
			cnt_q[i] = '0;
		end
	endtask

	task automatic model_clear_frame();
		pos_q = '0;
		etype_q = '0;
		hw_q = '0;
		flags_q = '0;
		captured_q = 1'b0;
	endtask

	// advance the predictor by one accepted word; queue a verdict on the last byte
	task automatic model_word(input logic op, input logic [7:0] b, input logic last,
			input logic [1:0] proto, input logic [15:0] sp, input logic [15:0] dp,
			input logic [31:0] src);
		int       hit;
		int       free_slot;
		int       len;
		logic     is_tcp;
		verdict_t v;
		hit = -1;
		free_slot = -1;
		if (op == OpClear) begin
			model_clear_table();
			return;
		end
		// header capture
		if (pos_q == 12)
			etype_q = {b, 8'h00};
		else if (pos_q == 13)
			etype_q[7:0] = b;
		else if (pos_q == 14)
			hw_q = b[3:0];
		if (pos_q >= 27 && int'(pos_q) == 27 + 4 * int'(hw_q)) begin
			flags_q = b;
			captured_q = 1'b1;
		end
		len = int'(pos_q) + 1;
		if (pos_q != PosMax)
			pos_q = pos_q + 1'b1;
		if (!last)
			return;
		is_tcp = proto == ProtoTcp;
		v.susp = (is_tcp || proto == ProtoUdp) && (port_watched(sp) || port_watched(dp));
		v.syn = is_tcp && len >= 34 && etype_q == EtherTypeIpv4 && captured_q &&
			(flags_q & FlagSyn) != 0 && (flags_q & FlagAck) == 0;
		if (v.susp)
			port_cnt_q = sat_add(port_cnt_q);
		if (v.syn)
			syn_cnt_q = sat_add(syn_cnt_q);
		// per-source table
		for (int i = 0; i < TableEntriesDef; i++) begin
			if (valid_q[i] && key_q[i] == src && hit < 0)
				hit = i;
			if (!valid_q[i] && free_slot < 0)
				free_slot = i;
		end
		v.heavy = 1'b0;
		v.untracked = 1'b0;
		v.pkts = '0;
		if (hit >= 0) begin
			v.heavy = cnt_q[hit] <= thr_q;
			cnt_q[hit] = sat_add(cnt_q[hit]);
			v.pkts = cnt_q[hit];
			v.heavy = v.heavy && v.pkts > thr_q;
		end else if (free_slot >= 0) begin
			valid_q[free_slot] = 1'b1;
			key_q[free_slot] = src;
			cnt_q[free_slot] = 32'd1;
			v.pkts = 32'd1;
			v.heavy = thr_q == 0;
		end else begin
			v.untracked = 1'b1;
		end
		v.syn_tot = syn_cnt_q;
		v.susp_tot = port_cnt_q;
		pending_verdicts.push_back(v);
		last_verdict = v;
		model_clear_frame();
	endtask

	// offer one word, with random gaps, and predict once it is taken
	task automatic send_word(input logic op, input logic [7:0] b, input logic last,
			input logic [1:0] proto, input logic [15:0] sp, input logic [15:0] dp,
			input logic [31:0] src);
		while (!no_idle && $urandom_range(99) < 28) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tlast <= last;
		s_axis_tdata <= {6'd0, src, dp, sp, proto, b};
		do @(posedge clk); while (!s_axis_tready);
		model_word(op, b, last, proto, sp, dp, src);
		if (op == OpClear)
			clears_sent++;
		else
			bytes_sent++;
	endtask

	// clear word with random noise on the other fields
	task automatic send_noisy_clear();
		send_word(OpClear, 8'($urandom), 1'($urandom), 2'($urandom), 16'($urandom),
			16'($urandom), $urandom);
	endtask

	// one frame built around the given header fields; stray clears when asked
	task automatic send_frame(input int len, input logic [15:0] etype, input logic [3:0] ihl,
			input logic [7:0] flags, input logic [1:0] proto, input logic [15:0] sp,
			input logic [15:0] dp, input logic [31:0] src, input bit stray_clears);
		logic [7:0] b;
		logic       last;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			if (i == 12)
				b = etype[15:8];
			else if (i == 13)
				b = etype[7:0];
			else if (i == 14)
				b = {4'h4, ihl};
			else if (i == 27 + 4 * int'(ihl))
				b = flags;
			last = i == len - 1;
			if (stray_clears && $urandom_range(99) < 1)
				send_noisy_clear();
			// metadata on earlier bytes is noise the block must ignore
			if (last)
				send_word(OpFrame, b, 1'b1, proto, sp, dp, src);
			else
				send_word(OpFrame, b, 1'b0, 2'($urandom), 16'($urandom), 16'($urandom),
					$urandom);
		end
		frames_sent++;
	endtask

	// threshold write once every result is out
	task automatic write_threshold(input logic [31:0] value);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (pending_verdicts.size() == 0);
		repeat (SettleCycles) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		thr_q = value;
	endtask

	function automatic logic [15:0] pick_port();
		case ($urandom_range(5))
			0: return 16'd21;
			1: return 16'd23;
			2: return 16'd445;
			3: return 16'd3389;
			default: return 16'($urandom);
		endcase
	endfunction

	// receiver side
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = HoldCycles;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= no_idle || $urandom_range(99) >= 28;
			end
		end
	end

	// result check against the oldest prediction
	always @(posedge clk) begin
		verdict_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			verdicts_seen++;
			if (pending_verdicts.size() == 0) begin
				report("unexpected word", 32'd0, m_axis_tdata[31:0]);
			end else begin
				e = pending_verdicts.pop_front();
				if (e.untracked)
					untracked_seen++;
				if (e.heavy)
					heavy_seen++;
				if (m_axis_tdata[0] !== e.susp)
					report("suspicious_port", 32'(e.susp), 32'(m_axis_tdata[0]));
				if (m_axis_tdata[1] !== e.syn)
					report("syn_without_ack", 32'(e.syn), 32'(m_axis_tdata[1]));
				if (m_axis_tdata[33:2] !== e.pkts)
					report("source_packets", e.pkts, m_axis_tdata[33:2]);
				if (m_axis_tdata[34] !== e.heavy)
					report("became_heavy", 32'(e.heavy), 32'(m_axis_tdata[34]));
				if (m_axis_tdata[35] !== e.untracked)
					report("source_untracked", 32'(e.untracked), 32'(m_axis_tdata[35]));
				if (m_axis_tdata[67:36] !== e.syn_tot)
					report("syn_total", e.syn_tot, m_axis_tdata[67:36]);
				if (m_axis_tdata[99:68] !== e.susp_tot)
					report("suspicious_total", e.susp_tot, m_axis_tdata[99:68]);
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("watchdog: no progress in %0d cycles", IdleLimit);
			$display("packet_anomaly_counter regression: fail");
			$finish;
		end
	end

	// stimulus
	initial begin
		logic [31:0] a_src;
		logic [31:0] b_src;
		logic [31:0] c_src;
		logic [31:0] thresholds [6];
		int          phase_start;
		int          phase_bytes;
		logic [31:0] src;
		a_src = 32'h0A00_0001;
		b_src = 32'hC0A8_0102;
		c_src = 32'h7F00_0001;
		thresholds = '{32'd0, 32'd3, 32'hFFFF_FFFF, 32'd1, 32'd7, 32'd1000};
		foreach (src_pool[i])
			src_pool[i] = $urandom;
		thr_q = ThresholdReset;
		model_clear_frame();
		model_clear_table();

		// directed frames: SYN placement, port classes, clear, tiny frames
		rows = '{
			'{0, 48, 16'h0800, 5, 8'h02, ProtoTcp, 1000, 80, a_src, 0, 1, 1},
			'{0, 48, 16'h0800, 5, 8'h12, ProtoTcp, 1000, 80, a_src, 0, 0, 2},
			'{0, 100, 16'h0800, 15, 8'h02, ProtoTcp, 1000, 80, a_src, 0, 1, 3},
			'{0, 40, 16'h0800, 0, 8'hFF, ProtoTcp, 1000, 80, a_src, 0, 0, 4},
			'{0, 40, 16'h0800, 0, 8'hEF, ProtoTcp, 1000, 80, a_src, 0, 1, 5},
			'{0, 33, 16'h0800, 0, 8'h02, ProtoTcp, 1000, 80, b_src, 0, 0, 1},
			'{0, 48, 16'h0800, 15, 8'h02, ProtoTcp, 1000, 80, b_src, 0, 0, 2},
			'{0, 48, 16'h86DD, 5, 8'h02, ProtoTcp, 1000, 80, b_src, 0, 0, 3},
			'{0, 1, 16'h0800, 5, 8'h02, ProtoUdp, 21, 80, c_src, 1, 0, 1},
			'{0, 1, 16'h0800, 5, 8'h00, ProtoTcp, 1000, 3389, c_src, 1, 0, 2},
			'{0, 1, 16'h0800, 5, 8'h00, ProtoUdp, 445, 80, c_src, 1, 0, 3},
			'{0, 1, 16'h0800, 5, 8'h00, ProtoTcp, 1000, 23, c_src, 1, 0, 4},
			'{0, 1, 16'h0800, 5, 8'h00, 2'd0, 1000, 21, c_src, 0, 0, 5},
			'{0, 48, 16'h0800, 5, 8'h02, 2'd3, 1000, 21, c_src, 0, 0, 6},
			'{1, 0, 16'h0, 0, 8'h0, 2'd0, 0, 0, 32'd0, 0, 0, 0},
			'{0, 48, 16'h0800, 5, 8'h02, ProtoTcp, 1000, 80, a_src, 0, 1, 1},
			'{0, 1, 16'h0, 0, 8'h0, 2'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0, 0, 1},
			'{0, 34, 16'h0800, 1, 8'h02, ProtoTcp, 1000, 80, a_src, 0, 1, 2}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[r]) begin
			if (rows[r].clr) begin
				send_word(OpClear, 8'h00, 1'b0, 2'd0, 16'd0, 16'd0, 32'd0);
			end else begin
				send_frame(rows[r].len, rows[r].etype, rows[r].ihl, rows[r].flags,
					rows[r].proto, rows[r].sp, rows[r].dp, rows[r].src, 0);
				if (last_verdict.susp !== rows[r].e_susp)
					report($sformatf("row %0d suspicious_port", r), 32'(rows[r].e_susp),
						32'(last_verdict.susp));
				if (last_verdict.syn !== rows[r].e_syn)
					report($sformatf("row %0d syn_without_ack", r), 32'(rows[r].e_syn),
						32'(last_verdict.syn));
				if (last_verdict.pkts !== rows[r].e_pkts)
					report($sformatf("row %0d source_packets", r), rows[r].e_pkts, last_verdict.pkts);
			end
		end

		// fill the table past its size with one-byte frames from distinct sources
		send_word(OpClear, 8'h00, 1'b0, 2'd0, 16'd0, 16'd0, 32'd0);
		for (int k = 0; k < FillSources; k++) begin
			send_frame(1, 16'h0, 4'h0, 8'h00, 2'd0, 16'd0, 16'd0, src_pool[k], 0);
			if (last_verdict.untracked !== (k >= TableEntriesDef))
				report($sformatf("fill %0d source_untracked", k), 32'(k >= TableEntriesDef),
					32'(last_verdict.untracked));
		end

		// random phases, each under its own threshold
		foreach (thresholds[p]) begin
			write_threshold(thresholds[p]);
			no_idle = p == 3;
			if (p == 2)
				hold_req = 1;
			phase_start = bytes_sent + clears_sent;
			phase_bytes = 0;
			while (phase_bytes < PhaseWords) begin
				src = ($urandom_range(9) == 0) ? $urandom : src_pool[$urandom_range(NumSources - 1)];
				if ($urandom_range(99) < 3) begin
					send_noisy_clear();
				end else if ($urandom_range(99) < 30) begin
					// well-formed IPv4 frame reaching the flags byte most of the time
					send_frame($urandom_range(34, 60),
						($urandom_range(9) == 0) ? 16'($urandom) : EtherTypeIpv4,
						4'($urandom_range(0, 7)), ($urandom_range(1) == 1) ? FlagSyn : 8'($urandom),
						2'($urandom_range(0, 3)), pick_port(), pick_port(), src, 1);
				end else begin
					send_frame($urandom_range(1, 6), 16'($urandom), 4'($urandom), 8'($urandom),
						2'($urandom_range(0, 3)), pick_port(), pick_port(), src, 1);
				end
				phase_bytes = bytes_sent + clears_sent - phase_start;
			end
		end
		no_idle = 0;

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		sent_all = 1;
		wait (pending_verdicts.size() == 0);
		repeat (SettleCycles) @(posedge clk);
		$display("covered %0d frame bytes in %0d frames, %0d clears, %0d results",
			bytes_sent, frames_sent, clears_sent, verdicts_seen);
		$display("six thresholds including 0 and max; %0d heavy and %0d untracked sources seen",
			heavy_seen, untracked_seen);
		if (errors == 0 && pending_verdicts.size() == 0) begin
			$display("packet_anomaly_counter regression: pass");
		end else begin
			$display("%0d mismatches", errors);
			$display("packet_anomaly_counter regression: fail");
		end
		$finish;
	end

endmodule
